// ===== src/sobel_pkg.sv =====
// Shared types, constants and state encodings for the Sobel edge magnitude block.
`timescale 1ns / 1ps

package sobel_pkg;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Frame geometry
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int MIN_DIM        = 2;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Datapath widths
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int GRAD_W  = 11;
    localparam int SUMSQ_W = 21;
    localparam int ROOT_W  = 16;

    // Sums of squares at or above this give a full-scale magnitude
    localparam logic [SUMSQ_W-1:0] SAT_LIMIT      = 21'd65281;
    localparam logic [ROOT_W-1:0]  ROOT_BIT_FIRST = 16'h4000;
    localparam logic [ROOT_W-1:0]  ROOT_BIT_LAST  = 16'h0001;
    localparam logic [CH_W-1:0]    MAG_MAX        = 8'hFF;

    localparam int QUEUE_DEPTH = 2;

    // Beat payloads
    typedef struct packed {
        logic            command;
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] red_edge;
        logic [CH_W-1:0] green_edge;
        logic [CH_W-1:0] blue_edge;
        logic            frame_last;
    } t_pix_out;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        t_pixel top;
        t_pixel mid;
        t_pixel bot;
    } t_column;

    // One window handed from the front end to the back end
    typedef struct packed {
        t_column left;
        t_column center;
        t_column right;
        logic    emit_a;     // result centered on the middle column
        logic    emit_b;     // row-end result centered on the right column
        logic    frame_end;  // row-end result closes the frame
    } t_job;

    localparam int JOB_W = $bits(t_job);
    localparam int RES_W = $bits(t_pix_out);

    typedef enum logic {
        F_IDLE,
        F_WORK
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_GRAD,
        B_SQR,
        B_ROOT,
        B_OUT
    } t_back_state;

endpackage

// ===== src/sobel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sobel_ram #(
    parameter int WIDTH = sobel_pkg::PIX_W,
    parameter int DEPTH = sobel_pkg::DEF_MAX_WIDTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/sobel_queue.sv =====
// Small register-based FIFO used between the front end, back end and result port.
`timescale 1ns / 1ps

module sobel_queue #(
    parameter int WIDTH = sobel_pkg::JOB_W,
    parameter int DEPTH = sobel_pkg::QUEUE_DEPTH,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CNTW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] ptr);
        ptr_next = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
    endfunction

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_data[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNTW'(1);
                2'b01:   r_count <= r_count - CNTW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/sobel_front.sv =====
// Front end: accepts pixels, runs the line stores and window, and queues windows.
`timescale 1ns / 1ps

module sobel_front #(
    parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sobel_pkg::t_pix_in i_pixel,
    output logic               o_busy,
    input  logic [CW-1:0]      i_last_col,
    input  logic [RW-1:0]      i_rows,
    output logic               o_job_push,
    output sobel_pkg::t_job    o_job,
    input  logic               i_job_full
);

    import sobel_pkg::*;

    t_front_state  r_state;
    t_front_state  n_state;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    t_pixel        r_px;
    logic          r_last;
    logic          r_drain;
    t_column       r_col1;
    t_column       r_col2;

    t_pixel upper_rd;
    t_pixel middle_rd;
    t_pixel upper_wr;
    t_job   job;
    logic   accept;
    logic   last_now;
    logic   drain_now;
    logic   emit_a;
    logic   emit_b;
    logic   need_push;
    logic   done;
    logic   ram_wr_en;

    assign accept    = i_push && (r_state == F_IDLE);
    assign last_now  = (r_col >= i_last_col);
    assign drain_now = (r_row >= i_rows);

    // Classify the pixel in hand
    assign emit_a    = (r_row != '0) && (r_col != '0);
    assign emit_b    = (r_row != '0) && r_last;
    assign need_push = emit_a || emit_b;
    assign done      = !need_push || !i_job_full;

    // Upper store takes the old middle row; the top row writes zeros
    assign upper_wr = (r_row == '0) ? '0 : middle_rd;

    // Build the shifted window; a new row starts from zero columns
    always_comb begin
        job.left      = (r_col == '0) ? '0 : r_col1;
        job.center    = (r_col == '0) ? '0 : r_col2;
        job.right.top = upper_rd;
        job.right.mid = middle_rd;
        job.right.bot = r_px;
        job.emit_a    = emit_a;
        job.emit_b    = emit_b;
        job.frame_end = r_drain;
    end

    assign o_job = job;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_WORK;
            F_WORK: if (done) n_state = F_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_busy     = 1'b1;
        ram_wr_en  = 1'b0;
        o_job_push = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_busy = 1'b0;
            end
            F_WORK: begin
                ram_wr_en  = done;
                o_job_push = need_push && !i_job_full;
            end
        endcase
    end

    // Advance window and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_col1  <= '0;
            r_col2  <= '0;
        end else begin
            r_state <= n_state;
            if (ram_wr_en) begin
                r_col1 <= job.center;
                r_col2 <= job.right;
                if (r_last) begin
                    r_col <= '0;
                    r_row <= r_drain ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // Capture the beat; drain items and the drain row count as black
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if ((i_pixel.command == CMD_DRAIN) || drain_now) begin
                r_px <= '0;
            end else begin
                r_px <= '{red: i_pixel.red_in, green: i_pixel.green_in,
                          blue: i_pixel.blue_in};
            end
            r_last  <= last_now;
            r_drain <= drain_now;
        end
    end

    sobel_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_upper_store (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(r_col),
        .i_wr_data(upper_wr),
        .i_rd_en  (accept),
        .i_rd_addr(r_col),
        .o_rd_data(upper_rd)
    );

    sobel_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_middle_store (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(r_col),
        .i_wr_data(r_px),
        .i_rd_en  (accept),
        .i_rd_addr(r_col),
        .o_rd_data(middle_rd)
    );

    a_accept_to_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_busy) |=> (r_state == F_WORK))
        else $error("accepted pixel did not start line store update");

    a_job_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> ((r_row != '0) && (o_job.emit_a || o_job.emit_b)))
        else $error("window queued without a result");

    a_row_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_wr_en && r_last) |=> (r_col == '0))
        else $error("column count did not wrap at row end");

endmodule

// ===== src/sobel_back.sv =====
// Back end: gradients, sum of squares and a digit-by-digit rounded square root.
`timescale 1ns / 1ps

module sobel_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_empty,
    input  sobel_pkg::t_job     i_job,
    output logic                o_job_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output sobel_pkg::t_pix_out o_res
);

    import sobel_pkg::*;

    localparam int LANES = 3;

    t_back_state r_state;
    t_back_state n_state;
    t_job        r_job;
    logic        r_phase_b;

    logic signed [GRAD_W-1:0] r_gx  [LANES];
    logic signed [GRAD_W-1:0] r_gy  [LANES];
    logic [SUMSQ_W-1:0]       r_sum [LANES];
    logic [ROOT_W-1:0]        r_rem [LANES];
    logic [ROOT_W-1:0]        r_res [LANES];
    logic [ROOT_W-1:0]        r_bit;

    t_column                    col_l;
    t_column                    col_m;
    t_column                    col_r;
    logic signed [GRAD_W-1:0]   gx_n  [LANES];
    logic signed [GRAD_W-1:0]   gy_n  [LANES];
    logic signed [2*GRAD_W-1:0] sqx   [LANES];
    logic signed [2*GRAD_W-1:0] sqy   [LANES];
    logic [SUMSQ_W-1:0]         sum_n [LANES];
    logic [ROOT_W:0]            trial [LANES];
    logic [ROOT_W-1:0]          rem_n [LANES];
    logic [ROOT_W-1:0]          res_n [LANES];
    logic [ROOT_W:0]            rounded [LANES];
    logic [CH_W-1:0]            mag   [LANES];
    logic                       go_b;

    function automatic logic [CH_W-1:0] chan(input t_pixel p, input int unsigned k);
        case (k)
            0:       chan = p.red;
            1:       chan = p.green;
            default: chan = p.blue;
        endcase
    endfunction

    function automatic logic signed [GRAD_W-1:0] widen(input logic [CH_W-1:0] v);
        widen = $signed({{(GRAD_W - CH_W){1'b0}}, v});
    endfunction

    // Select columns: the row-end result sees a zero column on its right
    always_comb begin
        col_l = r_phase_b ? r_job.center : r_job.left;
        col_m = r_phase_b ? r_job.right  : r_job.center;
        col_r = r_phase_b ? '0           : r_job.right;
    end

    // Sobel gradients per channel
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            gx_n[k] = (widen(chan(col_r.top, k)) + (widen(chan(col_r.mid, k)) <<< 1)
                       + widen(chan(col_r.bot, k)))
                    - (widen(chan(col_l.top, k)) + (widen(chan(col_l.mid, k)) <<< 1)
                       + widen(chan(col_l.bot, k)));
            gy_n[k] = (widen(chan(col_l.bot, k)) + (widen(chan(col_m.bot, k)) <<< 1)
                       + widen(chan(col_r.bot, k)))
                    - (widen(chan(col_l.top, k)) + (widen(chan(col_m.top, k)) <<< 1)
                       + widen(chan(col_r.top, k)));
        end
    end

    // Sum of squares per channel
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            sqx[k]   = r_gx[k] * r_gx[k];
            sqy[k]   = r_gy[k] * r_gy[k];
            sum_n[k] = SUMSQ_W'($unsigned(sqx[k])) + SUMSQ_W'($unsigned(sqy[k]));
        end
    end

    // One root digit per cycle
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            trial[k] = {1'b0, r_res[k]} + {1'b0, r_bit};
            if ({1'b0, r_rem[k]} >= trial[k]) begin
                rem_n[k] = r_rem[k] - trial[k][ROOT_W-1:0];
                res_n[k] = (r_res[k] >> 1) + r_bit;
            end else begin
                rem_n[k] = r_rem[k];
                res_n[k] = r_res[k] >> 1;
            end
        end
    end

    // Round to nearest and saturate
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            rounded[k] = (r_rem[k] > r_res[k]) ? {1'b0, r_res[k]} + (ROOT_W + 1)'(1)
                                               : {1'b0, r_res[k]};
            if ((r_sum[k] >= SAT_LIMIT) || (rounded[k] > (ROOT_W + 1)'(MAG_MAX))) begin
                mag[k] = MAG_MAX;
            end else begin
                mag[k] = rounded[k][CH_W-1:0];
            end
        end
    end

    assign o_res = '{red_edge: mag[0], green_edge: mag[1], blue_edge: mag[2],
                     frame_last: r_phase_b && r_job.frame_end};

    assign go_b = !r_phase_b && r_job.emit_b;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_job_empty) n_state = B_GRAD;
            B_GRAD:  n_state = B_SQR;
            B_SQR:   n_state = B_ROOT;
            B_ROOT:  if (r_bit == ROOT_BIT_LAST) n_state = B_OUT;
            B_OUT:   if (!i_res_full) n_state = go_b ? B_GRAD : B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            B_IDLE:  o_job_pop  = !i_job_empty;
            B_OUT:   o_res_push = !i_res_full;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_phase_b <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_job_pop) begin
                r_phase_b <= !i_job.emit_a;
            end else if (o_res_push && go_b) begin
                r_phase_b <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        case (r_state)
            B_GRAD: begin
                r_gx <= gx_n;
                r_gy <= gy_n;
            end
            B_SQR: begin
                for (int k = 0; k < LANES; k++) begin
                    r_sum[k] <= sum_n[k];
                    r_rem[k] <= sum_n[k][ROOT_W-1:0];
                    r_res[k] <= '0;
                end
                r_bit <= ROOT_BIT_FIRST;
            end
            B_ROOT: begin
                r_rem <= rem_n;
                r_res <= res_n;
                r_bit <= r_bit >> 2;
            end
            default: ;
        endcase
    end

    a_pop_starts_grad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == B_GRAD))
        else $error("window popped but gradient step skipped");

    a_root_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SQR) |-> ##9 (r_state == B_OUT))
        else $error("square root did not take eight digit steps");

    a_frame_last_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.frame_last) |-> (r_phase_b && r_job.emit_b))
        else $error("frame end flagged on a result that is not a row end");

endmodule

// ===== src/sobel_edge_magnitude_rgb.sv =====
// The front end is busy from each accepted pixel until that pixel's window, if it yields a
// result, is queued; the back end pops a window only when idle and gives two results for a
// row-end pixel, its pace set by the 8-step shared square root.
// A 2-entry window queue and a 2-entry result queue let the two ends stall independently.
// Reset (synchronous, active low) clears counters, window, queues and FSMs and loads
// a 640 x 480 geometry; line stores are not cleared, the top row overwrites them.
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  sobel_pkg::t_pix_in                  i_pixel,
    input  logic                                pop,
    output logic                                empty,
    output sobel_pkg::t_pix_out                 o_result,
    input  logic                                i_cfg_we,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sobel_pkg::CFG_W-1:0]         i_cfg_data
);

    import sobel_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int WXW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int HXW = (RW > CFG_W) ? RW : CFG_W;

    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;
    logic [WXW-1:0]   width_x;
    logic [WXW-1:0]   width_eff;
    logic [HXW-1:0]   height_x;
    logic [HXW-1:0]   height_eff;
    logic [CW-1:0]    last_col;
    logic [RW-1:0]    rows;

    logic     job_push;
    t_job     job_in;
    logic     job_full;
    logic     job_pop;
    t_job     job_head;
    logic     job_empty;
    logic     res_push;
    t_pix_out res_in;
    logic     res_full;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(RESET_WIDTH);
            r_image_height <= CFG_W'(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp geometry to the supported range
    always_comb begin
        width_x  = WXW'(r_image_width);
        height_x = HXW'(r_image_height);
        if (width_x < WXW'(MIN_DIM)) begin
            width_eff = WXW'(MIN_DIM);
        end else if (width_x > WXW'(MAX_WIDTH)) begin
            width_eff = WXW'(MAX_WIDTH);
        end else begin
            width_eff = width_x;
        end
        if (height_x < HXW'(MIN_DIM)) begin
            height_eff = HXW'(MIN_DIM);
        end else if (height_x > HXW'(MAX_HEIGHT)) begin
            height_eff = HXW'(MAX_HEIGHT);
        end else begin
            height_eff = height_x;
        end
        last_col = CW'(width_eff - WXW'(1));
        rows     = RW'(height_eff);
    end

    sobel_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_pixel   (i_pixel),
        .o_busy    (full),
        .i_last_col(last_col),
        .i_rows    (rows),
        .o_job_push(job_push),
        .o_job     (job_in),
        .i_job_full(job_full)
    );

    sobel_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_job_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_data (job_in),
        .o_full (job_full),
        .i_pop  (job_pop),
        .o_data (job_head),
        .o_empty(job_empty)
    );

    sobel_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_empty(job_empty),
        .i_job      (job_head),
        .o_job_pop  (job_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    sobel_queue #(
        .WIDTH(RES_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (o_result),
        .o_empty(empty)
    );

endmodule
